// File: hw/rtl/gbi_pkg.sv
// Shared constants and types for the grid bilinear interpolator.
`timescale 1ns / 1ps
`default_nettype none

package gbi_pkg;

   localparam int ADDR_W      = 14;
   localparam int VALUE_W     = 32;
   localparam int X_W         = 17;
   localparam int R_W         = 18;
   localparam int X_FRAC_BITS = 16;
   localparam int R_FRAC_BITS = 17;
   localparam int MID_W       = 36;
   localparam int RECIP_SHIFT = 24;
   localparam int QUEUE_DEPTH = 4;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   typedef struct packed {
      logic is_query;
      logic in_range;
      logic row_odd;
      logic col_odd;
   } gbi_tag_type;

endpackage

`default_nettype wire

// File: hw/rtl/gbi_req_if.sv
// Request channel: table loads and interpolation queries.
`timescale 1ns / 1ps
`default_nettype none

interface gbi_req_if
   import gbi_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic                      action;
   logic [ADDR_W-1:0]         table_address;
   logic signed [VALUE_W-1:0] table_value;
   logic [X_W-1:0]            x_coord;
   logic [R_W-1:0]            r_coord;

   modport source (output valid, action, table_address, table_value, x_coord, r_coord,
                   input ready);
   modport sink (input valid, action, table_address, table_value, x_coord, r_coord,
                 output ready);
endinterface

`default_nettype wire

// File: hw/rtl/gbi_rsp_if.sv
// Response channel: interpolated values with their saturation flag.
`timescale 1ns / 1ps
`default_nettype none

interface gbi_rsp_if
   import gbi_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] interp_value;
   logic                      saturated;

   modport source (output valid, interp_value, saturated, input ready);
   modport sink (input valid, interp_value, saturated, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/gbi_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module gbi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/gbi_queue.sv
// Short first-in first-out queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module gbi_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  full,
   output logic                  empty
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);

endmodule

`default_nettype wire

// File: hw/rtl/gbi_front.sv
// Front end: accepts words, scales coordinates and maps them onto the four table banks.
`timescale 1ns / 1ps
`default_nettype none

module gbi_front
   import gbi_pkg::*;
#(
   parameter int GRID_POINTS = 100,
   parameter int SAMPLE_BITS = 32,
   localparam int IDX_W   = $clog2(GRID_POINTS),
   localparam int HALF_W  = $clog2((GRID_POINTS + 1) / 2),
   localparam int BANK_AW = 2 * HALF_W,
   localparam int PX_W    = X_W + IDX_W,
   localparam int PR_W    = R_W + $clog2(5 * GRID_POINTS)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   gbi_req_if.sink                       req_if,
   input  wire logic                     push_ok,
   output logic                          push,
   output gbi_tag_type                   push_tag,
   output logic [3:0][BANK_AW-1:0]       push_addr,
   output logic signed [SAMPLE_BITS-1:0] push_data,
   output logic [PX_W-1:0]               push_fx,
   output logic [PR_W-1:0]               push_fr
);

   localparam int CELL_MAX    = GRID_POINTS - 1;
   localparam int TABLE_DEPTH = GRID_POINTS * GRID_POINTS;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + GRID_POINTS - 1) / GRID_POINTS;
   localparam int RPROD_W     = ADDR_W + RECIP_SHIFT;
   localparam int CX_W        = PX_W - X_FRAC_BITS;
   localparam int CR_W        = PR_W - R_FRAC_BITS;

   // Stage one: coordinate scaling and the row estimate of a load address.
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_query_ff, s1_query_in;
   logic [PX_W-1:0]               s1_px_ff, s1_px_in;
   logic [PR_W-1:0]               s1_pr_ff, s1_pr_in;
   logic [ADDR_W-1:0]             s1_row_ff, s1_row_in;
   logic [ADDR_W-1:0]             s1_addr_ff, s1_addr_in;
   logic                          s1_keep_ff, s1_keep_in;
   logic signed [SAMPLE_BITS-1:0] s1_data_ff, s1_data_in;
   logic [RPROD_W-1:0]            recip_prod;

   // Stage two: cell selection, fractions and bank addresses.
   logic                          s2_valid_ff, s2_valid_in;
   gbi_tag_type                   s2_tag_ff, s2_tag_in;
   logic [3:0][BANK_AW-1:0]       s2_addr_ff, s2_addr_in;
   logic signed [SAMPLE_BITS-1:0] s2_data_ff;
   logic [PX_W-1:0]               s2_fx_ff, s2_fx_in;
   logic [PR_W-1:0]               s2_fr_ff, s2_fr_in;

   logic [CX_W-1:0]   cell_x;
   logic [CR_W-1:0]   cell_r;
   logic [IDX_W-1:0]  lo_x, hi_x, lo_r, hi_r;
   logic [IDX_W-1:0]  wr_row, wr_col;
   logic [ADDR_W-1:0] wr_col_full;

   assign req_if.ready = push_ok;

   always_comb begin
      recip_prod  = RPROD_W'(req_if.table_address) * RPROD_W'(RECIP);
      s1_valid_in = req_if.valid;
      s1_query_in = (req_if.action == ACTION_QUERY);
      s1_px_in    = PX_W'(CELL_MAX) * PX_W'(req_if.x_coord);
      s1_pr_in    = PR_W'(5 * CELL_MAX) * PR_W'(req_if.r_coord);
      s1_row_in   = recip_prod[RPROD_W-1:RECIP_SHIFT];
      s1_addr_in  = req_if.table_address;
      s1_keep_in  = (32'(req_if.table_address) < 32'(TABLE_DEPTH));
      s1_data_in  = SAMPLE_BITS'(req_if.table_value);
   end

   always_comb begin
      logic [1:0]       bsel;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      cell_x = s1_px_ff[PX_W-1:X_FRAC_BITS];
      cell_r = s1_pr_ff[PR_W-1:R_FRAC_BITS];
      lo_x   = (cell_x >= CX_W'(CELL_MAX)) ? IDX_W'(CELL_MAX - 1) : cell_x[IDX_W-1:0];
      lo_r   = (cell_r >= CR_W'(CELL_MAX)) ? IDX_W'(CELL_MAX - 1) : cell_r[IDX_W-1:0];
      hi_x   = lo_x + IDX_W'(1);
      hi_r   = lo_r + IDX_W'(1);
      s2_fx_in = s1_px_ff - (PX_W'(lo_x) << X_FRAC_BITS);
      s2_fr_in = s1_pr_ff - (PR_W'(lo_r) << R_FRAC_BITS);

      wr_col_full = s1_addr_ff - ADDR_W'(s1_row_ff * ADDR_W'(GRID_POINTS));
      wr_row      = s1_row_ff[IDX_W-1:0];
      wr_col      = wr_col_full[IDX_W-1:0];

      for (int b = 0; b < 4; b++) begin
         bsel = 2'(b);
         row  = (lo_x[0] == bsel[1]) ? lo_x : hi_x;
         col  = (lo_r[0] == bsel[0]) ? lo_r : hi_r;
         if (!s1_query_ff) begin
            row = wr_row;
            col = wr_col;
         end
         s2_addr_in[b] = {HALF_W'(row >> 1), HALF_W'(col >> 1)};
      end

      s2_valid_in        = s1_valid_ff;
      s2_tag_in.is_query = s1_query_ff;
      s2_tag_in.in_range = s1_query_ff | s1_keep_ff;
      s2_tag_in.row_odd  = s1_query_ff ? lo_x[0] : wr_row[0];
      s2_tag_in.col_odd  = s1_query_ff ? lo_r[0] : wr_col[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (push_ok) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         s1_query_ff <= s1_query_in;
         s1_px_ff    <= s1_px_in;
         s1_pr_ff    <= s1_pr_in;
         s1_row_ff   <= s1_row_in;
         s1_addr_ff  <= s1_addr_in;
         s1_keep_ff  <= s1_keep_in;
         s1_data_ff  <= s1_data_in;
         s2_tag_ff   <= s2_tag_in;
         s2_addr_ff  <= s2_addr_in;
         s2_data_ff  <= s1_data_ff;
         s2_fx_ff    <= s2_fx_in;
         s2_fr_ff    <= s2_fr_in;
      end
   end

   assign push      = s2_valid_ff && push_ok;
   assign push_tag  = s2_tag_ff;
   assign push_addr = s2_addr_ff;
   assign push_data = s2_data_ff;
   assign push_fx   = s2_fx_ff;
   assign push_fr   = s2_fr_ff;

endmodule

`default_nettype wire

// File: hw/rtl/gbi_back.sv
// Back end: banked table access, the two-step blend and result saturation.
`timescale 1ns / 1ps
`default_nettype none

module gbi_back
   import gbi_pkg::*;
#(
   parameter int GRID_POINTS = 100,
   parameter int SAMPLE_BITS = 32,
   localparam int IDX_W   = $clog2(GRID_POINTS),
   localparam int HALF_W  = $clog2((GRID_POINTS + 1) / 2),
   localparam int BANK_AW = 2 * HALF_W,
   localparam int PX_W    = X_W + IDX_W,
   localparam int PR_W    = R_W + $clog2(5 * GRID_POINTS)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     pop_ok,
   output logic                          pop,
   input  wire gbi_tag_type              pop_tag,
   input  wire logic [3:0][BANK_AW-1:0]  pop_addr,
   input  wire logic signed [SAMPLE_BITS-1:0] pop_data,
   input  wire logic [PX_W-1:0]          pop_fx,
   input  wire logic [PR_W-1:0]          pop_fr,
   gbi_rsp_if.source                     rsp_if
);

   localparam int DIFF_W  = SAMPLE_BITS + 1;
   localparam int PROD_W  = DIFF_W + PR_W + 1;
   localparam int SUM_W   = PROD_W + 1;
   localparam int DX_W    = MID_W + 1;
   localparam int PRODX_W = DX_W + PX_W + 1;
   localparam int SUMX_W  = PRODX_W + 1;

   localparam logic signed [SUM_W-1:0]   RND_R   = SUM_W'(1) << (R_FRAC_BITS - 1);
   localparam logic signed [SUMX_W-1:0]  RND_X   = SUMX_W'(1) << (X_FRAC_BITS - 1);
   localparam logic signed [MID_W-1:0]   MID_MAX = {1'b0, {(MID_W - 1){1'b1}}};
   localparam logic signed [MID_W-1:0]   MID_MIN = {1'b1, {(MID_W - 1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] OUT_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};
   localparam logic signed [VALUE_W-1:0] OUT_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};

   logic adv;
   logic [SAMPLE_BITS-1:0] bank_rd [4];

   logic                 b1_valid_ff;
   logic                 b1_row_odd_ff, b1_col_odd_ff;
   logic [PX_W-1:0]      b1_fx_ff;
   logic [PR_W-1:0]      b1_fr_ff;

   logic                 b2_valid_ff;
   logic signed [PROD_W-1:0]      b2_prod_ff [2], b2_prod_in [2];
   logic signed [SAMPLE_BITS-1:0] b2_base_ff [2], b2_base_in [2];
   logic [PX_W-1:0]      b2_fx_ff;

   logic                 b3_valid_ff;
   logic signed [MID_W-1:0] b3_v_ff [2], b3_v_in [2];
   logic                 b3_hit_ff, b3_hit_in;
   logic [PX_W-1:0]      b3_fx_ff;

   logic                 b4_valid_ff;
   logic signed [PRODX_W-1:0] b4_prod_ff, b4_prod_in;
   logic signed [MID_W-1:0]   b4_base_ff;
   logic                 b4_hit_ff;

   logic                 out_valid_ff;
   logic signed [VALUE_W-1:0] out_value_ff, out_value_in;
   logic                 out_sat_ff, out_sat_in;

   logic [1:0] idx00, idx01, idx10, idx11;
   logic signed [SAMPLE_BITS-1:0] v00, v01, v10, v11;
   logic signed [DIFF_W-1:0]  r_diff [2];
   logic signed [SUM_W-1:0]   r_sum [2];
   logic [1:0]                r_clip;
   logic signed [DX_W-1:0]    x_diff;
   logic signed [SUMX_W-1:0]  x_sum;

   assign adv = !out_valid_ff || rsp_if.ready;
   assign pop = adv && pop_ok;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      gbi_ram #(
         .WIDTH (SAMPLE_BITS),
         .DEPTH (1 << BANK_AW)
      ) u_ram (
         .clock   (clock),
         .wr_en   (pop && !pop_tag.is_query && pop_tag.in_range &&
                   ({pop_tag.row_odd, pop_tag.col_odd} == 2'(b))),
         .wr_addr (pop_addr[0]),
         .wr_data (pop_data),
         .rd_en   (adv),
         .rd_addr (pop_addr[b]),
         .rd_data (bank_rd[b])
      );
   end

   // Neighbour selection and the blend along r.
   always_comb begin
      idx00 = {b1_row_odd_ff, b1_col_odd_ff};
      idx01 = {b1_row_odd_ff, !b1_col_odd_ff};
      idx10 = {!b1_row_odd_ff, b1_col_odd_ff};
      idx11 = {!b1_row_odd_ff, !b1_col_odd_ff};
      v00 = $signed(bank_rd[idx00]);
      v01 = $signed(bank_rd[idx01]);
      v10 = $signed(bank_rd[idx10]);
      v11 = $signed(bank_rd[idx11]);
      r_diff[0] = DIFF_W'(v01) - DIFF_W'(v00);
      r_diff[1] = DIFF_W'(v11) - DIFF_W'(v10);
      b2_base_in[0] = v00;
      b2_base_in[1] = v10;
      for (int k = 0; k < 2; k++) begin
         b2_prod_in[k] = r_diff[k] * $signed({1'b0, b1_fr_ff});
      end
   end

   // Rounding and clipping of the two intermediate values.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         r_sum[k] = SUM_W'(b2_base_ff[k]) + ((SUM_W'(b2_prod_ff[k]) + RND_R) >>> R_FRAC_BITS);
         r_clip[k] = !((&r_sum[k][SUM_W-1:MID_W-1]) || !(|r_sum[k][SUM_W-1:MID_W-1]));
         if (r_clip[k]) begin
            b3_v_in[k] = r_sum[k][SUM_W-1] ? MID_MIN : MID_MAX;
         end else begin
            b3_v_in[k] = r_sum[k][MID_W-1:0];
         end
      end
      b3_hit_in = |r_clip;
   end

   // Blend along x, then final rounding and saturation.
   always_comb begin
      x_diff     = DX_W'(b3_v_ff[1]) - DX_W'(b3_v_ff[0]);
      b4_prod_in = x_diff * $signed({1'b0, b3_fx_ff});
      x_sum      = SUMX_W'(b4_base_ff) + ((SUMX_W'(b4_prod_ff) + RND_X) >>> X_FRAC_BITS);
      out_sat_in = b4_hit_ff;
      if (!((&x_sum[SUMX_W-1:VALUE_W-1]) || !(|x_sum[SUMX_W-1:VALUE_W-1]))) begin
         out_value_in = x_sum[SUMX_W-1] ? OUT_MIN : OUT_MAX;
         out_sat_in   = 1'b1;
      end else begin
         out_value_in = x_sum[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         b4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         b1_valid_ff  <= pop && pop_tag.is_query;
         b2_valid_ff  <= b1_valid_ff;
         b3_valid_ff  <= b2_valid_ff;
         b4_valid_ff  <= b3_valid_ff;
         out_valid_ff <= b4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_row_odd_ff <= pop_tag.row_odd;
         b1_col_odd_ff <= pop_tag.col_odd;
         b1_fx_ff      <= pop_fx;
         b1_fr_ff      <= pop_fr;
         b2_prod_ff    <= b2_prod_in;
         b2_base_ff    <= b2_base_in;
         b2_fx_ff      <= b1_fx_ff;
         b3_v_ff       <= b3_v_in;
         b3_hit_ff     <= b3_hit_in;
         b3_fx_ff      <= b2_fx_ff;
         b4_prod_ff    <= b4_prod_in;
         b4_base_ff    <= b3_v_ff[0];
         b4_hit_ff     <= b3_hit_ff;
         out_value_ff  <= out_value_in;
         out_sat_ff    <= out_sat_in;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.interp_value = out_value_ff;
   assign rsp_if.saturated    = out_sat_ff;

endmodule

`default_nettype wire

// File: hw/rtl/grid_bilinear_interpolator.sv
// Top level of the grid bilinear interpolator: front end, word queue and back end.
// Throughput: one word per cycle, loads and queries alike, when neither the queue nor
// the response side stalls; the table sits in four RAM banks split by row and column
// parity, so the four neighbours are read in the same cycle.
// Reset clears the pipeline valid bits and the queue; the table is not cleared and
// entries read back undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module grid_bilinear_interpolator
   import gbi_pkg::*;
#(
   parameter int GRID_POINTS = 100,
   parameter int SAMPLE_BITS = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   gbi_req_if.sink    req_if,
   gbi_rsp_if.source  rsp_if
);

   localparam int IDX_W   = $clog2(GRID_POINTS);
   localparam int HALF_W  = $clog2((GRID_POINTS + 1) / 2);
   localparam int BANK_AW = 2 * HALF_W;
   localparam int PX_W    = X_W + IDX_W;
   localparam int PR_W    = R_W + $clog2(5 * GRID_POINTS);
   localparam int ENTRY_W = $bits(gbi_tag_type) + 4 * BANK_AW + SAMPLE_BITS + PX_W + PR_W;

   logic                          f_push;
   gbi_tag_type                   f_tag;
   logic [3:0][BANK_AW-1:0]       f_addr;
   logic signed [SAMPLE_BITS-1:0] f_data;
   logic [PX_W-1:0]               f_fx;
   logic [PR_W-1:0]               f_fr;

   logic                          q_full, q_empty;
   logic [ENTRY_W-1:0]            q_push_data, q_pop_data;

   logic                          b_pop;
   gbi_tag_type                   b_tag;
   logic [3:0][BANK_AW-1:0]       b_addr;
   logic signed [SAMPLE_BITS-1:0] b_data;
   logic [PX_W-1:0]               b_fx;
   logic [PR_W-1:0]               b_fr;

   gbi_front #(
      .GRID_POINTS (GRID_POINTS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .push_ok   (!q_full),
      .push      (f_push),
      .push_tag  (f_tag),
      .push_addr (f_addr),
      .push_data (f_data),
      .push_fx   (f_fx),
      .push_fr   (f_fr)
   );

   assign q_push_data = {f_tag, f_addr, f_data, f_fx, f_fr};

   gbi_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (q_push_data),
      .pop       (b_pop),
      .pop_data  (q_pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   assign {b_tag, b_addr, b_data, b_fx, b_fr} = q_pop_data;

   gbi_back #(
      .GRID_POINTS (GRID_POINTS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_ok   (!q_empty),
      .pop      (b_pop),
      .pop_tag  (b_tag),
      .pop_addr (b_addr),
      .pop_data (b_data),
      .pop_fx   (b_fx),
      .pop_fr   (b_fr),
      .rsp_if   (rsp_if)
   );

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the grid bilinear interpolator: table loads, queries and scoreboard.
`timescale 1ns / 1ps

module tb_top;
   import gbi_pkg::*;

   localparam int     GRID        = 100;
   localparam int     TABLE_DEPTH = GRID * GRID;
   localparam int     CELL_MAX    = GRID - 1;
   localparam longint X_SCALE     = CELL_MAX;
   localparam longint R_SCALE     = 5 * CELL_MAX;
   localparam longint MID_LIMIT   = longint'(1) <<< (MID_W - 1);
   localparam longint OUT_LIMIT   = longint'(1) <<< (VALUE_W - 1);
   localparam int     LATENCY     = 7;
   localparam int     WORD_TARGET = 1320;
   localparam int     CYCLE_LIMIT = 400000;

   typedef struct {
      logic                      action;
      logic [ADDR_W-1:0]         table_address;
      logic signed [VALUE_W-1:0] table_value;
      logic [X_W-1:0]            x_coord;
      logic [R_W-1:0]            r_coord;
   } lookup_word_type;

   typedef enum int {PACE_RANDOM, PACE_FULL, PACE_LIGHT, PACE_BURSTY} pace_type;

   class interp_scoreboard;
      longint                    samples[TABLE_DEPTH];
      logic signed [VALUE_W-1:0] want_value[$];
      logic                      want_flag[$];
      int unsigned               errors;
      int unsigned               checked;
      int unsigned               clipped_seen;

      function longint round_shift(longint v, int s);
         return (v + (longint'(1) <<< (s - 1))) >>> s;
      endfunction

      function longint saturate(longint v, longint limit, inout bit hit);
         if (v >= limit) begin
            hit = 1'b1;
            return limit - 1;
         end
         if (v < -limit) begin
            hit = 1'b1;
            return -limit;
         end
         return v;
      endfunction

      function void note_word(lookup_word_type w);
         longint px, pr, fx, fr, v00, v01, v10, v11, v0, v1, v;
         int     row, col;
         bit     hit;
         if (w.action == ACTION_WRITE) begin
            if (w.table_address < TABLE_DEPTH)
               samples[w.table_address] = longint'(w.table_value);
            return;
         end
         hit = 1'b0;
         px  = X_SCALE * longint'(w.x_coord);
         pr  = R_SCALE * longint'(w.r_coord);
         row = int'(px >>> X_FRAC_BITS) + 1;
         col = int'(pr >>> R_FRAC_BITS) + 1;
         if (row > CELL_MAX) row = CELL_MAX;
         if (col > CELL_MAX) col = CELL_MAX;
         fx  = px - (longint'(row - 1) <<< X_FRAC_BITS);
         fr  = pr - (longint'(col - 1) <<< R_FRAC_BITS);
         v00 = samples[(row - 1) * GRID + col - 1];
         v01 = samples[(row - 1) * GRID + col];
         v10 = samples[row * GRID + col - 1];
         v11 = samples[row * GRID + col];
         v0  = saturate(v00 + round_shift((v01 - v00) * fr, R_FRAC_BITS), MID_LIMIT, hit);
         v1  = saturate(v10 + round_shift((v11 - v10) * fr, R_FRAC_BITS), MID_LIMIT, hit);
         v   = saturate(v0 + round_shift((v1 - v0) * fx, X_FRAC_BITS), OUT_LIMIT, hit);
         want_value.push_back(v[VALUE_W-1:0]);
         want_flag.push_back(hit);
      endfunction

      function void check_result(logic signed [VALUE_W-1:0] got_value, logic got_flag);
         logic signed [VALUE_W-1:0] exp_value;
         logic                      exp_flag;
         checked++;
         if (want_value.size() == 0) begin
            $display("%0t: unexpected word, interp_value %0d saturated %0b",
                     $time, got_value, got_flag);
            errors++;
            return;
         end
         exp_value = want_value.pop_front();
         exp_flag  = want_flag.pop_front();
         if (exp_flag) clipped_seen++;
         if (got_value !== exp_value) begin
            $display("%0t: interp_value expected %0d, got %0d", $time, exp_value, got_value);
            errors++;
         end
         if (got_flag !== exp_flag) begin
            $display("%0t: saturated expected %0b, got %0b", $time, exp_flag, got_flag);
            errors++;
         end
      endfunction

      function int pending();
         return want_value.size();
      endfunction

      function void flag_leftovers();
         if (want_value.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, want_value.size());
            errors += want_value.size();
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   gbi_req_if req_bus ();
   gbi_rsp_if rsp_bus ();

   grid_bilinear_interpolator uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   interp_scoreboard board;
   pace_type         send_pace;
   pace_type         rsp_pace;
   bit               loaded[TABLE_DEPTH];
   int               known_cells[$];
   int unsigned      cycles;
   int unsigned      words_sent;
   int unsigned      loads_sent;
   int unsigned      queries_sent;
   int unsigned      ignored_sent;

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: run timed out", $time);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic int draw_wait(pace_type pace);
      case (pace)
         PACE_FULL:   return 0;
         PACE_LIGHT:  return $urandom_range(0, 2);
         PACE_BURSTY: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
         default:     return $urandom_range(0, 17);
      endcase
   endfunction

   function automatic logic signed [VALUE_W-1:0] draw_sample();
      case ($urandom_range(0, 9))
         6, 7:    return $urandom_range(0, 4000) - 2000;
         8:       return ($urandom_range(0, 1) == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         9:       return ($urandom_range(0, 1) == 1) ? 32'sh0000_0000 : -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic int row_of(logic [X_W-1:0] x);
      int n;
      n = int'((X_SCALE * longint'(x)) >>> X_FRAC_BITS) + 1;
      return (n > CELL_MAX) ? CELL_MAX : n;
   endfunction

   function automatic int col_of(logic [R_W-1:0] r);
      int n;
      n = int'((R_SCALE * longint'(r)) >>> R_FRAC_BITS) + 1;
      return (n > CELL_MAX) ? CELL_MAX : n;
   endfunction

   function automatic logic [X_W-1:0] x_in_row(int n);
      int lo, hi;
      lo = ((n - 1) * 65536 + CELL_MAX - 1) / CELL_MAX;
      hi = (n == CELL_MAX) ? 131071 : (n * 65536 + CELL_MAX - 1) / CELL_MAX - 1;
      if (n == CELL_MAX && $urandom_range(0, 1) == 1) hi = lo + 700;
      return X_W'($urandom_range(lo, hi));
   endfunction

   function automatic logic [R_W-1:0] r_in_col(int n);
      int lo, hi;
      lo = ((n - 1) * 131072 + 5 * CELL_MAX - 1) / (5 * CELL_MAX);
      hi = (n == CELL_MAX) ? 262143 : (n * 131072 + 5 * CELL_MAX - 1) / (5 * CELL_MAX) - 1;
      if (n == CELL_MAX && $urandom_range(0, 1) == 1) hi = lo + 300;
      return R_W'($urandom_range(lo, hi));
   endfunction

   task automatic send_word(input lookup_word_type w);
      int gap;
      gap = draw_wait(send_pace);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid         <= 1'b1;
      req_bus.action        <= w.action;
      req_bus.table_address <= w.table_address;
      req_bus.table_value   <= w.table_value;
      req_bus.x_coord       <= w.x_coord;
      req_bus.r_coord       <= w.r_coord;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      board.note_word(w);
      if (w.action == ACTION_QUERY) begin
         queries_sent++;
         words_sent++;
      end else if (w.table_address < TABLE_DEPTH) begin
         loads_sent++;
         words_sent++;
      end else begin
         ignored_sent++;
      end
   endtask

   task automatic load_entry(input int addr, input logic signed [VALUE_W-1:0] value);
      lookup_word_type w;
      w.action        = ACTION_WRITE;
      w.table_address = ADDR_W'(addr);
      w.table_value   = value;
      w.x_coord       = X_W'($urandom);
      w.r_coord       = R_W'($urandom);
      if (addr < TABLE_DEPTH) loaded[addr] = 1'b1;
      send_word(w);
   endtask

   task automatic query_at(input logic [X_W-1:0] x, input logic [R_W-1:0] r);
      lookup_word_type w;
      int              row, col, addr;
      row = row_of(x);
      col = col_of(r);
      for (int dr = -1; dr <= 0; dr++) begin
         for (int dc = -1; dc <= 0; dc++) begin
            addr = (row + dr) * GRID + col + dc;
            if (!loaded[addr]) load_entry(addr, draw_sample());
         end
      end
      known_cells.push_back(row * GRID + col);
      w.action        = ACTION_QUERY;
      w.table_address = ADDR_W'($urandom);
      w.table_value   = $urandom;
      w.x_coord       = x;
      w.r_coord       = r;
      send_word(w);
   endtask

   task automatic drain_results();
      int stall;
      forever begin
         stall = draw_wait(rsp_pace);
         repeat (stall) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         board.check_result(rsp_bus.interp_value, rsp_bus.saturated);
      end
   endtask

   initial begin
      int pick, spot;
      board                 = new();
      clock                 = 1'b0;
      reset                 = 1'b1;
      cycles                = 0;
      send_pace             = PACE_RANDOM;
      rsp_pace              = PACE_RANDOM;
      req_bus.valid         = 1'b0;
      req_bus.action        = ACTION_WRITE;
      req_bus.table_address = '0;
      req_bus.table_value   = '0;
      req_bus.x_coord       = '0;
      req_bus.r_coord       = '0;
      rsp_bus.ready         = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      fork
         drain_results();
      join_none

      // The origin cell holds the sample extremes.
      load_entry(0, 32'sh0000_0000);
      load_entry(1, 32'sh7FFF_FFFF);
      load_entry(GRID, 32'sh8000_0000);
      load_entry(GRID + 1, 32'sh0000_0001);
      query_at(17'd0, 18'd0);
      query_at(17'd661, 18'd264);
      query_at(17'd330, 18'd132);
      // A step of one half unit gives exact rounding ties in both directions.
      load_entry(GRID + 2, 32'sh0001_0001);
      load_entry(2 * GRID + 1, 32'sh0000_0000);
      load_entry(2 * GRID + 2, -32'sh0001_0000);
      query_at(17'd662, 18'd301);
      query_at(17'd1323, 18'd529);
      // The far corner, extrapolated hard enough to clip at both stages.
      load_entry(98 * GRID + 98, 32'sh8000_0000);
      load_entry(98 * GRID + 99, 32'sh7FFF_FFFF);
      load_entry(99 * GRID + 98, 32'sh7FFF_FFFF);
      load_entry(99 * GRID + 99, 32'sh8000_0000);
      query_at(17'd131071, 18'd262143);
      query_at(17'd65536, 18'd131072);
      query_at(17'd64880, 18'd25950);
      // Loads beyond the table must leave it untouched.
      load_entry(TABLE_DEPTH, 32'sh1234_5678);
      load_entry(16383, -32'sd1);
      query_at(17'd0, 18'd0);

      while (words_sent < WORD_TARGET) begin
         if ($urandom_range(0, 149) == 0) begin
            send_pace = pace_type'($urandom_range(0, 3));
            rsp_pace  = pace_type'($urandom_range(0, 3));
         end
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            spot = known_cells[$urandom_range(0, known_cells.size() - 1)];
            query_at(x_in_row(spot / GRID), r_in_col(spot % GRID));
         end else if (pick < 60) begin
            case ($urandom_range(0, 3))
               0:       query_at(X_W'($urandom_range(0, 131071)),
                                 R_W'($urandom_range(0, 262143)));
               1:       query_at(X_W'($urandom_range(0, 65535)),
                                 R_W'($urandom_range(0, 262143)));
               default: query_at(X_W'($urandom_range(0, 65535)),
                                 R_W'($urandom_range(0, 26500)));
            endcase
         end else if (pick < 88) begin
            load_entry($urandom_range(0, TABLE_DEPTH - 1), draw_sample());
         end else if (pick < 93) begin
            load_entry($urandom_range(TABLE_DEPTH, 16383), $urandom);
         end else begin
            spot = known_cells[$urandom_range(0, known_cells.size() - 1)];
            load_entry(spot - $urandom_range(0, 1) * GRID - $urandom_range(0, 1), draw_sample());
         end
      end
      @(negedge clock);
      req_bus.valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (4 * LATENCY) @(posedge clock);
      board.flag_leftovers();
      $display("Sent %0d table loads, %0d queries and %0d loads outside the table.",
               loads_sent, queries_sent, ignored_sent);
      $display("Checked %0d result words, %0d of them clipped.",
               board.checked, board.clipped_seen);
      if (board.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
